@@ rtl/pbce_pkg.sv @@
// Package with shared types and constants of the Bezier curve evaluator.
package pbce_pkg;
    localparam int MaxSegments = 16;
    localparam int FracBits = 16;
    localparam int IdxW = $clog2(MaxSegments);

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_RESTART = 2'd1;
    localparam logic [1:0] CMD_ADVANCE = 2'd2;
    localparam logic [1:0] CMD_EVAL    = 2'd3;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [3:0]         segment_index;
        logic [31:0]        segment_begin;
        logic [31:0]        segment_finish;
        logic signed [31:0] ctrl_a;
        logic signed [31:0] ctrl_b;
        logic signed [31:0] ctrl_c;
        logic signed [31:0] ctrl_d;
        logic [31:0]        time_delta;
    } req_t;

    typedef struct packed {
        logic signed [31:0] position;
        logic [3:0]         matched_segment;
        logic               past_all_segments;
    } rsp_t;

    // Handshake between the sequencer and the divider.
    typedef struct packed {
        logic start;
    } div_ctl_t;
endpackage

@@ rtl/pbce_if.sv @@
// Valid/ready channel interfaces of the curve evaluator.
interface pbce_req_if;
    import pbce_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pbce_rsp_if;
    import pbce_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pbce_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/pbce_div.sv @@
// Restoring divider, one quotient bit per cycle, for the local time.
module pbce_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pbce_pkg::div_ctl_t   ctl,
    input  logic [31:0]          num,
    input  logic [31:0]          den,
    output logic                 done,
    output logic [32:0]          quo
);
    import pbce_pkg::*;

    localparam int NumW = 32 + FracBits;
    localparam int CntW = $clog2(NumW + 1);

    logic [NumW-1:0] q_reg, q_next;
    logic [32:0]     r_reg, r_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [33:0]     trial;

    // One shift and subtract per cycle.
    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg, q_reg[NumW-1]} - {2'b00, den};
        if (ctl.start)
        begin
            q_next    = {num, {FracBits{1'b0}}};
            r_next    = '0;
            cnt_next  = CntW'(NumW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[33])
            begin
                r_next = trial[32:0];
                q_next = {q_reg[NumW-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[31:0], q_reg[NumW-1]};
                q_next = {q_reg[NumW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign done = done_reg;
    assign quo  = q_reg[32:0];

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.start |=> busy_reg)
        else $error("divider did not start");
    a_cnt_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> cnt_reg == '0 || $past(ctl.start) == 1'b0)
        else $error("divider count left over");
endmodule

@@ rtl/piecewise_bezier_curve_eval_core.sv @@
// Top level of the piecewise cubic Bezier curve evaluator.
//
// Requests arrive on req (valid/ready). A load request stores one segment,
// a restart request clears the elapsed time, an advance request adds a
// delta with saturation. These give no result, and the block takes the next
// request in the following cycle. An evaluate request gives one result on
// rsp (valid/ready). The segment count register is written on cfg; the user
// must write it only while the block is idle, which the block does not enforce.
// An evaluate request searches the segments one per cycle (up to 16), runs
// a 48-step shift-subtract divider for the local time, then six lerps on the
// single shared multiplier, each a multiply state and an add state. A
// zero-length segment skips the divider, and when no segment matches the
// result is the last segment's end point with past_all_segments set.
// The block holds one request at a time and is not ready meanwhile.
// After reset the elapsed time is zero and the count is one; segment
// entries hold nothing defined until loaded. If the receiver stalls, the
// result stays in the output register and no new request is taken.
module piecewise_bezier_curve_eval_core (
    input logic       clk,
    input logic       rst_n,
    pbce_req_if.sink  req,
    pbce_rsp_if.source rsp,
    pbce_cfg_if.sink  cfg
);
    import pbce_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_MUL    = 3'd3;
    localparam logic [2:0] ST_ADD    = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    logic [31:0] begin_mem  [MaxSegments];
    logic [31:0] finish_mem [MaxSegments];
    logic [31:0] ctrl_a_mem [MaxSegments];
    logic [31:0] ctrl_b_mem [MaxSegments];
    logic [31:0] ctrl_c_mem [MaxSegments];
    logic [31:0] ctrl_d_mem [MaxSegments];

    logic [2:0]  state_reg, state_next;
    logic [4:0]  count_reg;
    logic [31:0] elapsed_reg;
    logic [IdxW:0] idx_reg, idx_next;
    logic [IdxW-1:0] last_idx;
    logic [IdxW:0] n_eff;
    logic [32:0] u_reg;
    logic [2:0]  step_reg;
    logic signed [31:0] p_reg [4];
    logic signed [65:0] prod_reg;
    logic [31:0] len;
    rsp_t        rsp_reg;
    logic        rsp_valid_reg;
    div_ctl_t    div_ctl;
    logic        div_done;
    logic [32:0] div_quo;
    logic [31:0] seg_b_reg, seg_f_reg;
    logic        hit;
    logic [32:0] sum;
    logic signed [31:0] lerp_a, lerp_b;
    logic signed [32:0] diff;
    logic signed [31:0] lerp_res;

    // Effective segment count, clamped to 1..MaxSegments.
    always_comb
    begin
        if (count_reg == '0)
            n_eff = (IdxW+1)'(1);
        else if (32'(count_reg) > MaxSegments)
            n_eff = (IdxW+1)'(MaxSegments);
        else
            n_eff = (IdxW+1)'(count_reg);
    end
    assign last_idx = IdxW'(n_eff - 1'b1);

    assign req.ready = (state_reg == ST_IDLE) && !rsp_valid_reg;
    assign cfg.ready = 1'b1;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;

    assign hit   = (seg_b_reg <= elapsed_reg) && (elapsed_reg <= seg_f_reg);
    assign len   = seg_f_reg - seg_b_reg;
    assign sum   = {1'b0, elapsed_reg} + {1'b0, req.data.time_delta};

    // Lerp operand selection for the six steps of de Casteljau.
    always_comb
    begin
        case (step_reg)
            3'd0: begin lerp_a = p_reg[0]; lerp_b = p_reg[1]; end
            3'd1: begin lerp_a = p_reg[1]; lerp_b = p_reg[2]; end
            3'd2: begin lerp_a = p_reg[2]; lerp_b = p_reg[3]; end
            3'd3: begin lerp_a = p_reg[0]; lerp_b = p_reg[1]; end
            3'd4: begin lerp_a = p_reg[1]; lerp_b = p_reg[2]; end
            default: begin lerp_a = p_reg[0]; lerp_b = p_reg[1]; end
        endcase
    end
    assign diff = 33'(lerp_b) - 33'(lerp_a);
    assign lerp_res = 32'(66'(lerp_a) + (prod_reg >>> FracBits));

    assign div_ctl.start = (state_reg == ST_SEARCH) && idx_reg < n_eff && hit
                           && len != '0;

    pbce_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (div_ctl),
        .num  (elapsed_reg - seg_b_reg),
        .den  (len),
        .done (div_done),
        .quo  (div_quo)
    );

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid && req.ready && req.data.cmd == CMD_EVAL)
                begin
                    state_next = ST_SEARCH;
                    idx_next   = '0;
                end
            end
            ST_SEARCH:
            begin
                if (idx_reg >= n_eff)
                    state_next = ST_OUT;
                else if (hit)
                    state_next = (len == '0) ? ST_MUL : ST_DIV;
                else
                    idx_next = idx_reg + 1'b1;
            end
            ST_DIV:
                if (div_done)
                    state_next = ST_MUL;
            ST_MUL:
                state_next = ST_ADD;
            ST_ADD:
                state_next = (step_reg == 3'd5) ? ST_OUT : ST_MUL;
            ST_OUT:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= 5'd1;
            elapsed_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            idx_reg       <= '0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (cfg.valid && cfg.ready)
                count_reg <= cfg.data;
            if (rsp_valid_reg && rsp.ready)
                rsp_valid_reg <= 1'b0;
            if (req.valid && req.ready)
            begin
                if (req.data.cmd == CMD_RESTART)
                    elapsed_reg <= '0;
                else if (req.data.cmd == CMD_ADVANCE)
                    elapsed_reg <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            end
            if (state_reg == ST_SEARCH && idx_reg < n_eff && hit)
                step_reg <= '0;
            else if (state_reg == ST_ADD)
                step_reg <= step_reg + 1'b1;
            if (state_reg == ST_OUT)
                rsp_valid_reg <= 1'b1;
        end
    end

    // Segment table writes.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready && req.data.cmd == CMD_LOAD)
        begin
            begin_mem[req.data.segment_index]  <= req.data.segment_begin;
            finish_mem[req.data.segment_index] <= req.data.segment_finish;
            ctrl_a_mem[req.data.segment_index] <= req.data.ctrl_a;
            ctrl_b_mem[req.data.segment_index] <= req.data.ctrl_b;
            ctrl_c_mem[req.data.segment_index] <= req.data.ctrl_c;
            ctrl_d_mem[req.data.segment_index] <= req.data.ctrl_d;
        end
    end

    // Segment times are read one step ahead, at the index the search visits next.
    always_ff @(posedge clk)
    begin
        seg_b_reg <= begin_mem[idx_next[IdxW-1:0]];
        seg_f_reg <= finish_mem[idx_next[IdxW-1:0]];
    end

    // Datapath: control points, shared multiplier, result.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SEARCH)
        begin
            if (idx_reg >= n_eff)
            begin
                rsp_reg.position          <= ctrl_d_mem[last_idx];
                rsp_reg.matched_segment   <= 4'(last_idx);
                rsp_reg.past_all_segments <= 1'b1;
            end
            else if (hit)
            begin
                p_reg[0] <= ctrl_a_mem[idx_reg[IdxW-1:0]];
                p_reg[1] <= ctrl_b_mem[idx_reg[IdxW-1:0]];
                p_reg[2] <= ctrl_c_mem[idx_reg[IdxW-1:0]];
                p_reg[3] <= ctrl_d_mem[idx_reg[IdxW-1:0]];
                rsp_reg.matched_segment   <= 4'(idx_reg[IdxW-1:0]);
                rsp_reg.past_all_segments <= 1'b0;
                u_reg <= '0;
            end
        end
        if (state_reg == ST_DIV && div_done)
            u_reg <= div_quo;
        if (state_reg == ST_MUL)
            prod_reg <= 66'(diff) * $signed({1'b0, u_reg});
        if (state_reg == ST_ADD)
        begin
            case (step_reg)
                3'd0: p_reg[0] <= lerp_res;
                3'd1: p_reg[1] <= lerp_res;
                3'd2: p_reg[2] <= lerp_res;
                3'd3: p_reg[0] <= lerp_res;
                3'd4: p_reg[1] <= lerp_res;
                default: rsp_reg.position <= lerp_res;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> state_reg == ST_IDLE)
        else $error("ready outside idle");
    a_out_valid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT |=> rsp_valid_reg)
        else $error("result not raised");
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ADD |-> step_reg <= 3'd5)
        else $error("lerp step out of range");
    a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SEARCH |-> idx_reg <= n_eff)
        else $error("search index past count");
endmodule
